>>> sv/ctrf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the CAN transmit change-rate filter.
package ctrf_pkg;

    localparam int ID_COUNT = 2048;
    localparam int ID_W     = 11;
    localparam int IDX_W    = $clog2(ID_COUNT);
    localparam int PAY_W    = 64;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int MEM_W    = 1 + PAY_W + TIME_W;

    localparam logic [ID_W:0]      ID_LIMIT  = (ID_W + 1)'(ID_COUNT);
    localparam logic [TIME_W-1:0]  MIN_RESET = 32'd25000;
    localparam logic [TIME_W-1:0]  MAX_RESET = 32'd50000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [PAY_W-1:0]  frame_payload;
        logic [TIME_W-1:0] now_us;
        logic              batch_last;
    } t_ctrf_in;

    typedef struct packed {
        logic send_frame;
        logic first_seen;
        logic payload_changed;
        logic batch_end;
    } t_ctrf_out;

    typedef struct packed {
        logic              in_range;
        logic [IDX_W-1:0]  idx;
        logic [PAY_W-1:0]  payload;
        logic [TIME_W-1:0] now_us;
        logic              batch_last;
    } t_ctrf_job;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_WRITE
    } t_ctrf_state;

endpackage

>>> sv/ctrf_front.sv
`timescale 1ns / 1ps
// Front end: accepts offered frames, classifies their identifiers and queues them.
module ctrf_front
    import ctrf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_ctrf_in  i_in_word,
    input  logic      i_clearing,
    output logic      o_job_valid,
    output t_ctrf_job o_job,
    input  logic      i_job_pop
);

    t_ctrf_job  r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push;
    t_ctrf_job  w_job;

    assign full        = (r_cnt == 2'd2) || i_clearing;
    assign w_push      = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rptr];

    always_comb begin
        w_job.in_range   = ({1'b0, i_in_word.frame_id} < ID_LIMIT);
        w_job.idx        = i_in_word.frame_id[IDX_W-1:0];
        w_job.payload    = i_in_word.frame_payload;
        w_job.now_us     = i_in_word.now_us;
        w_job.batch_last = i_in_word.batch_last;
    end

    always_comb begin
        n_wptr = w_push ? ~r_wptr : r_wptr;
        n_rptr = i_job_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, i_job_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_job;
        end
    end

endmodule

>>> sv/ctrf_back.sv
`timescale 1ns / 1ps
// Back end: identifier table, send decision, write-back and result queue.
module ctrf_back
    import ctrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_ctrf_job         i_job,
    output logic              o_job_pop,
    output logic              o_clearing,
    input  logic [TIME_W-1:0] i_min_interval,
    input  logic [TIME_W-1:0] i_max_interval,
    output logic              empty,
    input  logic              pop,
    output t_ctrf_out         o_out_word
);

    logic [MEM_W-1:0] r_mem [ID_COUNT];
    logic [MEM_W-1:0] r_rd_data;
    t_ctrf_job        r_job;
    t_ctrf_state      r_state, n_state;
    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;
    logic             w_clr_done;

    t_ctrf_out        r_oq [2];
    logic             r_owptr, r_orptr;
    logic [1:0]       r_ocnt;
    logic             w_ofull, w_opush, w_opop;

    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_addr;
    logic [MEM_W-1:0]  w_mem_wdata;

    logic              w_valid, w_changed, w_send;
    logic [TIME_W-1:0] w_elapsed;
    t_ctrf_out         w_result;

    assign w_ofull    = (r_ocnt == 2'd2);
    assign w_opop     = pop && !empty;
    assign empty      = (r_ocnt == 2'd0);
    assign o_out_word = r_oq[r_orptr];
    assign w_clr_done = (r_clr_addr == IDX_W'(ID_COUNT - 1));

    always_comb begin
        w_valid   = r_rd_data[MEM_W-1] && r_job.in_range;
        w_elapsed = r_job.now_us - r_rd_data[TIME_W-1:0];
        w_changed = w_valid && (r_rd_data[TIME_W +: PAY_W] != r_job.payload);
        if (!w_valid) begin
            w_send = 1'b1;
        end else if (w_changed) begin
            w_send = (w_elapsed >= i_min_interval);
        end else begin
            w_send = (w_elapsed >= i_max_interval);
        end
        w_result.send_frame      = w_send;
        w_result.first_seen      = !w_valid;
        w_result.payload_changed = w_changed;
        w_result.batch_end       = r_job.batch_last;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (w_clr_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_job_valid && !w_ofull) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_READ;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_clearing  = 1'b0;
        o_job_pop   = 1'b0;
        w_opush     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_job.idx;
        w_mem_wdata = {1'b1, r_job.payload, r_job.now_us};
        case (r_state)
            ST_CLEAR: begin
                o_clearing  = 1'b1;
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_addr;
                w_mem_wdata = '0;
            end
            ST_READ: begin
                o_job_pop = i_job_valid && !w_ofull;
            end
            ST_WRITE: begin
                w_opush  = 1'b1;
                w_mem_we = w_send && r_job.in_range;
            end
            default: begin
                o_clearing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_owptr    <= 1'b0;
            r_orptr    <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_owptr    <= w_opush ? ~r_owptr : r_owptr;
            r_orptr    <= w_opop ? ~r_orptr : r_orptr;
            r_ocnt     <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (o_job_pop) begin
            r_rd_data <= r_mem[i_job.idx];
            r_job     <= i_job;
        end
        if (w_opush) begin
            r_oq[r_owptr] <= w_result;
        end
    end

endmodule

>>> sv/can_tx_change_rate_filter_top.sv
`timescale 1ns / 1ps
// Top level of the CAN transmit change-rate filter.
// A word accepted on push passes through the front queue, the table read and the result queue.
// The back end takes a new word only after the table read and write-back of the last one.
// Reset is synchronous; afterwards a clearing pass invalidates every table entry.
// During the clearing pass full stays high; configuration writes are still taken.
module can_tx_change_rate_filter_top
    import ctrf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_ctrf_in             i_in_word,
    output logic                 empty,
    input  logic                 pop,
    output t_ctrf_out            o_out_word,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [TIME_W-1:0] r_min_interval;
    logic [TIME_W-1:0] r_max_interval;
    logic              w_clearing;
    logic              w_job_valid;
    logic              w_job_pop;
    t_ctrf_job         w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_RESET;
            r_max_interval <= MAX_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                REG_MAX_INTERVAL: r_max_interval <= i_cfg_data;
                default: begin
                    r_min_interval <= r_min_interval;
                end
            endcase
        end
    end

    ctrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .i_clearing  (w_clearing),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    ctrf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job),
        .o_job_pop      (w_job_pop),
        .o_clearing     (w_clearing),
        .i_min_interval (r_min_interval),
        .i_max_interval (r_max_interval),
        .empty          (empty),
        .pop            (pop),
        .o_out_word     (o_out_word)
    );

    a_clear_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> full)
        else $error("word accepted during table clearing");

    a_reset_starts_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> (full && empty))
        else $error("clearing pass not started after reset");

    a_pop_needs_job : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> w_job_valid)
        else $error("back end took a job from an empty queue");

    a_result_follows_job : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job_pop && empty && !w_clearing) |=> ##1 !empty)
        else $error("job taken without a result being produced");

endmodule
